// ----- hdl/mgc_pkg.sv -----
// Shared types, constants and saturating helpers for the gradient controller.
package mgc_pkg;

    // Iterations of the descent per item
    localparam int GD_ITERATIONS = 5;
    // Step 0.15 and momentum 0.5 in Q16.16
    localparam logic signed [31:0] STEP_ALPHA    = 32'sd9830;
    localparam logic signed [31:0] MOMENTUM_BETA = 32'sd32768;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_A_ROW0   = 3'd0,
        CFG_A_ROW1   = 3'd1,
        CFG_B_PAIR   = 3'd2,
        CFG_C_PAIR   = 3'd3,
        CFG_TRACK_W  = 3'd4,
        CFG_EFFORT_W = 3'd5,
        CFG_FLOOR    = 3'd6,
        CFG_CEILING  = 3'd7
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PRED = 5'b00010,
        S_GRAD = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    // Saturate a 33-bit sum to 32 bits
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        return sat33(s);
    endfunction

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} - {b[31], b};
        return sat33(s);
    endfunction

endpackage

// ----- hdl/mgc_fxmul.sv -----
// Shared Q16.16 multiplier: round to nearest, saturate, registered result.
module mgc_fxmul
    import mgc_pkg::*;
(
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [31:0] o_p
);

    logic signed [63:0] w_prod;
    logic signed [63:0] w_rnd;
    logic signed [63:0] w_shr;
    logic signed [31:0] n_p;
    logic signed [31:0] r_p;

    // Form the exact product, add half an LSB and floor
    assign w_prod = 64'(i_a) * 64'(i_b);
    assign w_rnd  = w_prod + 64'sd32768;
    assign w_shr  = w_rnd >>> 16;

    // Saturate to 32 bits
    always_comb begin
        if (w_shr > 64'sd2147483647) begin
            n_p = 32'sh7fff_ffff;
        end else if (w_shr < -64'sd2147483648) begin
            n_p = 32'sh8000_0000;
        end else begin
            n_p = w_shr[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

// ----- hdl/mpc_momentum_gradient_controller_unit.sv -----
// Top level of the momentum gradient-descent predictive controller.
// Each item (setpoint, measured) runs five descent iterations on one shared
// Q16.16 multiplier. An iteration runs one prediction step per step of the
// prediction horizon and then one gradient and momentum update per control
// increment; the multiplier is used once per cycle at most. The next item
// can be accepted in the cycle after the result is loaded into the output
// register. The input side stalls while an item is at work; a finished drive
// waits in the output register.
module mpc_momentum_gradient_controller_unit
    import mgc_pkg::*;
#(
    parameter int PRED_HORIZON = 10,
    parameter int CTRL_HORIZON = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_setpoint,
    input  logic signed [31:0] i_measured,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_drive
);

    localparam int KW = (PRED_HORIZON > 1) ? $clog2(PRED_HORIZON) : 1;
    localparam int JW = (CTRL_HORIZON > 1) ? $clog2(CTRL_HORIZON) : 1;
    localparam int OP_LAST_PRED = 9;
    localparam int OP_LAST_GRAD = 5;

    // Configuration registers
    logic signed [31:0] r_a00, r_a01, r_a10, r_a11;
    logic signed [31:0] r_b0, r_b1, r_c0, r_c1;
    logic signed [31:0] r_qw, r_rw, r_floor, r_ceil;

    // Sequencer and datapath registers
    t_state             r_state;
    logic [2:0]         r_it;
    logic [KW-1:0]      r_k;
    logic [JW-1:0]      r_j;
    logic [3:0]         r_op;
    logic signed [31:0] r_sp, r_meas;
    logic signed [31:0] r_s0, r_s1, r_u, r_n0, r_n1, r_y, r_t, r_gr;
    logic signed [31:0] r_g   [CTRL_HORIZON];
    logic signed [31:0] r_inc [CTRL_HORIZON];
    logic signed [31:0] r_mom [CTRL_HORIZON];
    logic signed [31:0] r_drive;
    logic signed [31:0] r_out;
    logic               r_ovalid;

    logic signed [31:0] w_ma, w_mb, w_p;
    logic signed [31:0] w_q2, w_r2;
    logic [JW-1:0]      w_ci;
    logic [JW-1:0]      w_idx;
    logic signed [31:0] w_inc_sel;
    logic signed [31:0] w_err;
    logic signed [31:0] w_upd;
    logic signed [31:0] w_dsum, w_dclamp;
    logic               w_in_acc, w_out_acc;
    logic               w_last_k, w_last_j, w_last_it;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = r_ovalid && !i_out_stall;
    assign w_q2      = sat_add(r_qw, r_qw);
    assign w_r2      = sat_add(r_rw, r_rw);
    assign w_last_k  = (r_k == KW'(PRED_HORIZON - 1));
    assign w_last_j  = (r_j == JW'(CTRL_HORIZON - 1));
    assign w_last_it = (r_it == 3'(GD_ITERATIONS - 1));

    // Pick the increment used by this prediction step
    assign w_ci      = (int'(r_k) < CTRL_HORIZON) ? JW'(r_k) : JW'(CTRL_HORIZON - 1);
    assign w_idx     = (r_state == S_PRED) ? w_ci : r_j;
    assign w_inc_sel = r_inc[w_idx];
    assign w_err     = sat_sub(r_y, r_sp);
    assign w_upd     = sat_add(r_t, w_p);

    // Final drive with clamp; with crossed limits a value below the floor
    // takes the floor and any other value the ceiling
    assign w_dsum = sat_add(r_drive, r_inc[0]);
    always_comb begin
        if (w_dsum < r_floor) begin
            w_dclamp = r_floor;
        end else if (w_dsum > r_ceil) begin
            w_dclamp = r_ceil;
        end else begin
            w_dclamp = w_dsum;
        end
    end

    // Select the multiplier operands for this cycle
    always_comb begin
        w_ma = r_a00;
        w_mb = r_s0;
        if (r_state == S_PRED) begin
            unique case (r_op)
                4'd0:    begin w_ma = r_a00; w_mb = r_s0; end
                4'd1:    begin w_ma = r_a01; w_mb = r_s1; end
                4'd2:    begin w_ma = r_a10; w_mb = r_s0; end
                4'd3:    begin w_ma = r_a11; w_mb = r_s1; end
                4'd4:    begin w_ma = r_b0;  w_mb = r_u;  end
                4'd5:    begin w_ma = r_b1;  w_mb = r_u;  end
                4'd6:    begin w_ma = r_c0;  w_mb = r_n0; end
                4'd7:    begin w_ma = r_c1;  w_mb = r_n1; end
                default: begin w_ma = r_a00; w_mb = r_s0; end
            endcase
        end else begin
            unique case (r_op)
                4'd0:    begin w_ma = w_q2;          w_mb = r_g[r_j];   end
                4'd1:    begin w_ma = w_r2;          w_mb = w_inc_sel;  end
                4'd3:    begin w_ma = STEP_ALPHA;    w_mb = r_gr;       end
                4'd4:    begin w_ma = MOMENTUM_BETA; w_mb = r_mom[r_j]; end
                default: begin w_ma = r_a00;         w_mb = r_s0;       end
            endcase
        end
    end

    mgc_fxmul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_p)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a00 <= '0; r_a01 <= '0; r_a10 <= '0; r_a11 <= '0;
            r_b0  <= '0; r_b1  <= '0; r_c0  <= '0; r_c1  <= '0;
            r_qw    <= 32'sd65536;
            r_rw    <= 32'sd6554;
            r_floor <= -32'sd6553600;
            r_ceil  <= 32'sd6553600;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_A_ROW0:   begin r_a00 <= i_cfg_data[63:32]; r_a01 <= i_cfg_data[31:0]; end
                CFG_A_ROW1:   begin r_a10 <= i_cfg_data[63:32]; r_a11 <= i_cfg_data[31:0]; end
                CFG_B_PAIR:   begin r_b0  <= i_cfg_data[63:32]; r_b1  <= i_cfg_data[31:0]; end
                CFG_C_PAIR:   begin r_c0  <= i_cfg_data[63:32]; r_c1  <= i_cfg_data[31:0]; end
                CFG_TRACK_W:  r_qw    <= i_cfg_data[31:0];
                CFG_EFFORT_W: r_rw    <= i_cfg_data[31:0];
                CFG_FLOOR:    r_floor <= i_cfg_data[31:0];
                CFG_CEILING:  r_ceil  <= i_cfg_data[31:0];
                default:      ;
            endcase
        end
    end

    // Sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_it     <= '0;
            r_k      <= '0;
            r_j      <= '0;
            r_op     <= '0;
            r_drive  <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < CTRL_HORIZON; i++) begin
                r_inc[i] <= '0;
                r_mom[i] <= '0;
                r_g[i]   <= '0;
            end
        end else begin
            // drop the result once taken, unless a new one is loaded
            if (w_out_acc && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_sp    <= i_setpoint;
                        r_meas  <= i_measured;
                        r_s0    <= i_measured;
                        r_s1    <= '0;
                        r_u     <= r_drive;
                        r_it    <= '0;
                        r_k     <= '0;
                        r_op    <= '0;
                        for (int i = 0; i < CTRL_HORIZON; i++) r_g[i] <= '0;
                        r_state <= S_PRED;
                    end
                end
                S_PRED: begin
                    // one prediction step
                    unique case (r_op)
                        4'd0: r_u  <= sat_add(r_u, w_inc_sel);
                        4'd1: r_n0 <= w_p;
                        4'd2: r_n0 <= sat_add(r_n0, w_p);
                        4'd3: r_n1 <= w_p;
                        4'd4: r_n1 <= sat_add(r_n1, w_p);
                        4'd5: r_n0 <= sat_add(r_n0, w_p);
                        4'd6: r_n1 <= sat_add(r_n1, w_p);
                        4'd7: r_y  <= w_p;
                        4'd8: begin
                            r_y  <= sat_add(r_y, w_p);
                            r_s0 <= r_n0;
                            r_s1 <= r_n1;
                        end
                        default: begin
                            // fold the error into every tail sum that covers this step
                            for (int i = 0; i < CTRL_HORIZON; i++) begin
                                if (i <= int'(r_k)) r_g[i] <= sat_add(r_g[i], w_err);
                            end
                        end
                    endcase
                    if (r_op == 4'(OP_LAST_PRED)) begin
                        r_op <= '0;
                        if (w_last_k) begin
                            r_j     <= '0;
                            r_state <= S_GRAD;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end else begin
                        r_op <= r_op + 1'b1;
                    end
                end
                S_GRAD: begin
                    // gradient and momentum update of one increment
                    unique case (r_op)
                        4'd1: r_t  <= w_p;
                        4'd2: r_gr <= sat_add(sat_sub(32'sd0, r_t), w_p);
                        4'd4: r_t  <= w_p;
                        4'd5: begin
                            r_inc[r_j] <= sat_sub(w_inc_sel, w_upd);
                            r_mom[r_j] <= w_upd;
                        end
                        default: ;
                    endcase
                    if (r_op == 4'(OP_LAST_GRAD)) begin
                        r_op <= '0;
                        if (!w_last_j) begin
                            r_j <= r_j + 1'b1;
                        end else if (w_last_it) begin
                            r_state <= S_FIN;
                        end else begin
                            r_it    <= r_it + 1'b1;
                            r_k     <= '0;
                            r_s0    <= r_meas;
                            r_s1    <= '0;
                            r_u     <= r_drive;
                            for (int i = 0; i < CTRL_HORIZON; i++) r_g[i] <= '0;
                            r_state <= S_PRED;
                        end
                    end else begin
                        r_op <= r_op + 1'b1;
                    end
                end
                S_FIN: begin
                    r_drive <= w_dclamp;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!r_ovalid || w_out_acc) begin
                        r_out    <= r_drive;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_drive     = r_out;

    // The operation counter stays inside its schedule
    a_op_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_op <= 4'(OP_LAST_PRED))
        else $error("operation counter out of range");

    // An accepted item starts the prediction at its first step
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_PRED) && (r_k == '0) && (r_op == '0) && (r_it == '0))
        else $error("item did not start prediction");

    // A taken result leaves the output empty unless a new one is loaded
    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && (r_state != S_OUT)) |=> !o_out_valid)
        else $error("result repeated");

    // Gradient phase never runs past the control horizon
    a_grad_j: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GRAD) |-> (int'(r_j) < CTRL_HORIZON))
        else $error("increment index out of range");

endmodule
